// ===== rtl/core/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared widths, product index tables and types for the 3x3 inverse block.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int ELEM_W        = 32;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int COF_W         = PROD_W + 1;
  localparam int DPP_W         = 2 * ELEM_W + 1;   // column-0 element times cofactor half
  localparam int DET_W         = ELEM_W + COF_W + 2;
  localparam int QUOT_W        = ELEM_W;
  localparam int N_ELEM        = 9;
  localparam int N_PROD        = 2 * N_ELEM;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic [3:0] elem_idx_t;

  // cofactor j = a[PROD_L[2j]]*a[PROD_R[2j]] - a[PROD_L[2j+1]]*a[PROD_R[2j+1]]
  localparam elem_idx_t PROD_L [N_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam elem_idx_t PROD_R [N_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  typedef struct packed {
    logic              singular;
    logic [N_ELEM-1:0] neg;
  } div_ctl_t;

  // working width of the divider remainder
  function automatic int num_width(int frac_bits);
    int a;
    int b;
    a = COF_W + 2 * frac_bits + 2;
    b = DET_W + 1 + QUOT_W;
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/m3inv_if.sv =====
// ----------------------------------------------------------------------------
// m3inv_if
// Request channels: input matrix and inverse result, valid/ready.
// ----------------------------------------------------------------------------
interface m3inv_mat_if import m3inv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3inv_res_if import m3inv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [QUOT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                     singular;
  logic                     overflowed;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  overflowed, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  overflowed, output ready);
endinterface

// ===== rtl/core/m3inv_divider.sv =====
// ----------------------------------------------------------------------------
// m3inv_divider
// Nine-lane pipelined restoring divider, one quotient bit per stage,
// with rounding offset pre-added, saturation and sign fix in the last stage.
// ----------------------------------------------------------------------------
module m3inv_divider import m3inv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [num_width(FRAC_BITS)-1:0] in_num [N_ELEM],
  input  logic [DET_W:0]           in_dv,
  input  div_ctl_t                 in_ctl,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [QUOT_W-1:0] out_quot [N_ELEM],
  output logic                     out_singular,
  output logic                     out_overflowed
);

  localparam int WW  = num_width(FRAC_BITS);
  localparam int NST = QUOT_W + 1;
  localparam logic [QUOT_W:0] LIM_NEG = (QUOT_W + 1)'(1) << (QUOT_W - 1);
  localparam logic [QUOT_W:0] LIM_POS = LIM_NEG - (QUOT_W + 1)'(1);

  logic [NST-1:0]    v_r;
  logic [WW-1:0]     rem_r [NST][N_ELEM];
  logic [QUOT_W-1:0] q_r   [NST][N_ELEM];
  logic [N_ELEM-1:0] ovf_r [NST];
  logic [DET_W:0]    dv_r  [NST];
  div_ctl_t          ctl_r [NST];
  logic [NST:0]      rdy;

  logic                     out_valid_r;
  logic signed [QUOT_W-1:0] res_r [N_ELEM];
  logic                     sing_r;
  logic                     ovfl_r;

  always_comb begin
    rdy[NST] = !out_valid_r || out_ready;
    for (int s = NST - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic              v_in;
    logic [DET_W:0]    dv_in;
    div_ctl_t          ctl_in;
    logic [WW-1:0]     rem_nxt [N_ELEM];
    logic [QUOT_W-1:0] q_nxt   [N_ELEM];
    logic [N_ELEM-1:0] ovf_nxt;

    if (s == 0) begin : g_first
      logic [WW-1:0] dtop;
      assign v_in   = in_valid;
      assign dv_in  = in_dv;
      assign ctl_in = in_ctl;
      assign dtop   = WW'(in_dv) << QUOT_W;
      always_comb begin
        for (int l = 0; l < N_ELEM; l++) begin
          rem_nxt[l] = in_num[l];
          q_nxt[l]   = '0;
          ovf_nxt[l] = (in_num[l] >= dtop);   // quotient reaches 2^32
        end
      end
    end else begin : g_bit
      localparam int B = QUOT_W - s;
      logic [WW-1:0] dsh;
      assign v_in   = v_r[s-1];
      assign dv_in  = dv_r[s-1];
      assign ctl_in = ctl_r[s-1];
      assign dsh    = WW'(dv_r[s-1]) << B;
      always_comb begin
        ovf_nxt = ovf_r[s-1];
        for (int l = 0; l < N_ELEM; l++) begin
          if (rem_r[s-1][l] >= dsh) begin
            rem_nxt[l] = rem_r[s-1][l] - dsh;
            q_nxt[l]   = q_r[s-1][l] | (QUOT_W'(1) << B);
          end else begin
            rem_nxt[l] = rem_r[s-1][l];
            q_nxt[l]   = q_r[s-1][l];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
        ovf_r[s] <= ovf_nxt;
        dv_r[s]  <= dv_in;
        ctl_r[s] <= ctl_in;
      end
    end
  end

  // rounding is already in the quotient; clip to the signed range
  logic [QUOT_W:0]          mag  [N_ELEM];
  logic [QUOT_W:0]          clip [N_ELEM];
  logic [N_ELEM-1:0]        sat;
  logic signed [QUOT_W-1:0] res_nxt [N_ELEM];

  always_comb begin
    for (int l = 0; l < N_ELEM; l++) begin
      mag[l]  = ovf_r[NST-1][l] ? (LIM_NEG << 1) : {1'b0, q_r[NST-1][l]};
      sat[l]  = mag[l] > (ctl_r[NST-1].neg[l] ? LIM_NEG : LIM_POS);
      clip[l] = sat[l] ? (ctl_r[NST-1].neg[l] ? LIM_NEG : LIM_POS) : mag[l];
      if (ctl_r[NST-1].singular) begin
        res_nxt[l] = '0;
      end else if (ctl_r[NST-1].neg[l]) begin
        res_nxt[l] = -$signed(clip[l][QUOT_W-1:0]);
      end else begin
        res_nxt[l] = $signed(clip[l][QUOT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NST]) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      res_r  <= res_nxt;
      sing_r <= ctl_r[NST-1].singular;
      ovfl_r <= !ctl_r[NST-1].singular && (|sat);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quot       = res_r;
  assign out_singular   = sing_r;
  assign out_overflowed = ovfl_r;

  logic any_nz;
  always_comb begin
    any_nz = 1'b0;
    for (int l = 0; l < N_ELEM; l++) begin
      any_nz = any_nz | (res_r[l] != '0);
    end
  end

  a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sing_r |-> !ovfl_r)
    else $error("singular result flagged overflow");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sing_r |-> !any_nz)
    else $error("singular result not zero");

  a_stage0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !rdy[1] |=> v_r[0] && $stable(dv_r[0]))
    else $error("stalled divider entry lost");

endmodule

// ===== rtl/core/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse
// Pipelined 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one row-major matrix a00..a22 per request, signed with
//   FRAC_BITS fraction bits. out_chan returns the inverse r00..r22 in the
//   same format, rounded to nearest (ties away from zero) and saturated,
//   plus singular (determinant exactly zero, all elements zero) and
//   overflowed (some element clipped).
//   Throughput: one request per cycle while out_chan is not stalled. Each
//   stage holds its own valid bit, so bubbles close up and a stall on
//   out_chan backs up stage by stage. Pipeline: 6 front stages (products,
//   cofactors, determinant partials, determinant, magnitudes) and 34 in the
//   divider, which retires one quotient bit per stage in all nine lanes.
//   Reset (rst_n low, synchronous) empties the pipe; no other state is kept.
//   With out_chan.ready low the result is held and in_chan.ready stays high
//   until the pipe is full.
// ----------------------------------------------------------------------------
module matrix3_inverse import m3inv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  m3inv_mat_if.sink   in_chan,
  m3inv_res_if.source out_chan
);

  localparam int WW  = num_width(FRAC_BITS);
  localparam int NFS = 6;   // front stages ahead of the divider

  logic [NFS-1:0] v_r;
  logic [NFS:0]   rdy;
  logic           div_in_ready;

  always_comb begin
    rdy[NFS] = div_in_ready;
    for (int k = NFS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end
  assign in_chan.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NFS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  logic signed [ELEM_W-1:0] a_in [N_ELEM];
  assign a_in[0] = in_chan.a00;
  assign a_in[1] = in_chan.a01;
  assign a_in[2] = in_chan.a02;
  assign a_in[3] = in_chan.a10;
  assign a_in[4] = in_chan.a11;
  assign a_in[5] = in_chan.a12;
  assign a_in[6] = in_chan.a20;
  assign a_in[7] = in_chan.a21;
  assign a_in[8] = in_chan.a22;

  // stage 1: eighteen 32x32 products; keep column 0 for the determinant
  logic signed [PROD_W-1:0] p1_nxt [N_PROD];
  logic signed [PROD_W-1:0] p1_r   [N_PROD];
  logic signed [ELEM_W-1:0] e1_r   [3];

  always_comb begin
    for (int k = 0; k < N_PROD; k++) begin
      p1_nxt[k] = a_in[PROD_L[k]] * a_in[PROD_R[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r    <= p1_nxt;
      e1_r[0] <= a_in[0];
      e1_r[1] <= a_in[3];
      e1_r[2] <= a_in[6];
    end
  end

  // stage 2: cofactors
  logic signed [COF_W-1:0]  c2_r [N_ELEM];
  logic signed [ELEM_W-1:0] e2_r [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int j = 0; j < N_ELEM; j++) begin
        c2_r[j] <= COF_W'(p1_r[2*j]) - COF_W'(p1_r[2*j+1]);
      end
      e2_r <= e1_r;
    end
  end

  // stage 3: column-0 times cofactor, split into low and high halves
  logic signed [DPP_W-1:0] lo3_r [3];
  logic signed [DPP_W-1:0] hi3_r [3];
  logic signed [COF_W-1:0] c3_r  [N_ELEM];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int k = 0; k < 3; k++) begin
        lo3_r[k] <= e2_r[k] * $signed({1'b0, c2_r[k][ELEM_W-1:0]});
        hi3_r[k] <= e2_r[k] * $signed(c2_r[k][COF_W-1:ELEM_W]);
      end
      c3_r <= c2_r;
    end
  end

  // stage 4: recombine halves
  logic signed [DET_W-1:0] t4_r [3];
  logic signed [COF_W-1:0] c4_r [N_ELEM];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        t4_r[k] <= (DET_W'(hi3_r[k]) <<< ELEM_W) + DET_W'(lo3_r[k]);
      end
      c4_r <= c3_r;
    end
  end

  // stage 5: determinant
  logic signed [DET_W-1:0] det5_r;
  logic signed [COF_W-1:0] c5_r [N_ELEM];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      det5_r <= t4_r[0] + t4_r[1] + t4_r[2];
      c5_r   <= c4_r;
    end
  end

  // stage 6: magnitudes, signs, divider operands.
  // num = |C| * 2^(2F+1) + |D|, divisor = 2|D| gives the rounded quotient.
  logic [DET_W-1:0] md;
  logic [COF_W-1:0] mc [N_ELEM];
  logic [WW-1:0]    num6_nxt [N_ELEM];
  div_ctl_t         ctl6_nxt;
  logic [WW-1:0]    num6_r [N_ELEM];
  logic [DET_W:0]   dv6_r;
  div_ctl_t         ctl6_r;

  always_comb begin
    md = det5_r[DET_W-1] ? DET_W'(-det5_r) : DET_W'(det5_r);
    ctl6_nxt.singular = (det5_r == '0);
    for (int j = 0; j < N_ELEM; j++) begin
      mc[j] = c5_r[j][COF_W-1] ? COF_W'(-c5_r[j]) : COF_W'(c5_r[j]);
      ctl6_nxt.neg[j] = c5_r[j][COF_W-1] ^ det5_r[DET_W-1];
      num6_nxt[j] = (WW'(mc[j]) << (2 * FRAC_BITS + 1)) + WW'(md);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      num6_r <= num6_nxt;
      dv6_r  <= {md, 1'b0};
      ctl6_r <= ctl6_nxt;
    end
  end

  logic signed [QUOT_W-1:0] quot [N_ELEM];

  m3inv_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (v_r[NFS-1]),
    .in_ready       (div_in_ready),
    .in_num         (num6_r),
    .in_dv          (dv6_r),
    .in_ctl         (ctl6_r),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_quot       (quot),
    .out_singular   (out_chan.singular),
    .out_overflowed (out_chan.overflowed)
  );

  assign out_chan.r00 = quot[0];
  assign out_chan.r01 = quot[1];
  assign out_chan.r02 = quot[2];
  assign out_chan.r10 = quot[3];
  assign out_chan.r11 = quot[4];
  assign out_chan.r12 = quot[5];
  assign out_chan.r20 = quot[6];
  assign out_chan.r21 = quot[7];
  assign out_chan.r22 = quot[8];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[0])
    else $error("accepted request missing from stage 1");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NFS-1] && !div_in_ready |=> v_r[NFS-1] && $stable(dv6_r))
    else $error("stalled operands changed");

  a_sing_dv: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NFS-1] |-> (ctl6_r.singular == (dv6_r == '0)))
    else $error("singular flag disagrees with divisor");

endmodule
